FILE: hw/rtl/gble_pkg.sv
// Shared types and codes for the gap-buffer line editor.
// Holds the command and response transaction structs and the mode codes.
// No dependencies.
`timescale 1ns / 1ps

package gble_pkg;

    localparam int CHAR_W    = 8;
    localparam int MODE_W    = 3;
    localparam int POS_W     = 10;
    localparam int OUT_CNT_W = 11;

    // Command modes
    localparam logic [MODE_W-1:0] MODE_LEFT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RIGHT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BACK   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAR_W-1:0] char_in;
        logic [POS_W-1:0]  position;
    } gble_cmd_t;

    typedef struct packed {
        logic [CHAR_W-1:0]    char_out;
        logic                 char_valid;
        logic [OUT_CNT_W-1:0] cursor;
        logic [OUT_CNT_W-1:0] text_length;
        logic                 overflow;
    } gble_rsp_t;

endpackage

FILE: hw/rtl/gble_ram.sv
// Simple dual-port stack memory: one write port, one read port, registered read.
// Used for both halves of the gap buffer. Depends on gble_pkg for the data width.
`timescale 1ns / 1ps

module gble_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [gble_pkg::CHAR_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [gble_pkg::CHAR_W-1:0] rdata
);
    import gble_pkg::*;

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/gap_buffer_line_editor.sv
// Gap-buffer line editor: text held as two stacks in RAM meeting at the cursor.
// The response is registered in the cycle after the command is accepted.
// A new command waits until the last one is through its RAM read and write-back, and while rsp_stall holds a response.
// Reset clears the counts, the FSM and the response valid; RAM contents are
// not cleared, entries are only read below the counts. No clearing pass.
`timescale 1ns / 1ps

module gap_buffer_line_editor #(
    parameter int CAPACITY = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gble_pkg::gble_cmd_t cmd,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    output gble_pkg::gble_rsp_t rsp,
    output logic                rsp_valid,
    input  logic                rsp_stall
);
    import gble_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int TW = CW + 1;
    localparam int PW = (TW > POS_W) ? TW : POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [TW-1:0] CAP_T = TW'(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t           state_reg;
    logic [CW-1:0]    lc_reg;
    logic [CW-1:0]    rc_reg;
    logic [CW-1:0]    lc_next;
    logic [CW-1:0]    rc_next;
    gble_cmd_t        cmd_reg;
    gble_rsp_t        rsp_reg;
    gble_rsp_t        rsp_next;
    logic             rsp_valid_reg;
    logic             accept;

    logic [TW-1:0]    total;
    logic [PW-1:0]    lc_ext;
    logic [PW-1:0]    tot_ext;
    logic [PW-1:0]    pos_in;
    logic [PW-1:0]    pos_ex;
    logic [PW-1:0]    ridx_in;
    logic [CW-1:0]    lc_m1;
    logic [CW-1:0]    rc_m1;

    logic             l_we;
    logic [AW-1:0]    l_waddr;
    logic [CHAR_W-1:0] l_wdata;
    logic [AW-1:0]    l_raddr;
    logic [CHAR_W-1:0] l_rdata;
    logic             r_we;
    logic [AW-1:0]    r_waddr;
    logic [CHAR_W-1:0] r_wdata;
    logic [AW-1:0]    r_raddr;
    logic [CHAR_W-1:0] r_rdata;

    // Handshake
    assign cmd_stall = !((state_reg == S_IDLE) && (!rsp_valid_reg || !rsp_stall));
    assign accept    = cmd_valid && !cmd_stall;
    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // Count arithmetic shared by both phases
    assign total   = {1'b0, lc_reg} + {1'b0, rc_reg};
    assign lc_ext  = PW'(lc_reg);
    assign tot_ext = PW'(total);
    assign lc_m1   = lc_reg - 1'b1;
    assign rc_m1   = rc_reg - 1'b1;
    assign pos_in  = PW'(cmd.position);
    assign pos_ex  = PW'(cmd_reg.position);
    // Right stack is stored reversed: index = total - 1 - position
    assign ridx_in = tot_ext - pos_in - 1'b1;

    // Read addresses, issued on the accepting edge
    always_comb
    begin
        l_raddr = '0;
        r_raddr = '0;
        case (cmd.mode)
            MODE_LEFT:
            begin
                l_raddr = lc_m1[AW-1:0];
            end
            MODE_RIGHT:
            begin
                r_raddr = rc_m1[AW-1:0];
            end
            MODE_READ:
            begin
                l_raddr = pos_in[AW-1:0];
                r_raddr = ridx_in[AW-1:0];
            end
            default:
            begin
                l_raddr = '0;
            end
        endcase
    end

    // Execute phase: write-back, count update and response
    always_comb
    begin
        lc_next  = lc_reg;
        rc_next  = rc_reg;
        l_we     = 1'b0;
        l_waddr  = lc_reg[AW-1:0];
        l_wdata  = r_rdata;
        r_we     = 1'b0;
        r_waddr  = rc_reg[AW-1:0];
        r_wdata  = l_rdata;
        rsp_next = '0;
        case (cmd_reg.mode)
            MODE_LEFT:
            begin
                if (lc_reg != '0 && rc_reg != CAP_C)
                begin
                    r_we    = 1'b1;
                    lc_next = lc_reg - 1'b1;
                    rc_next = rc_reg + 1'b1;
                end
            end
            MODE_RIGHT:
            begin
                if (rc_reg != '0 && lc_reg != CAP_C)
                begin
                    l_we    = 1'b1;
                    lc_next = lc_reg + 1'b1;
                    rc_next = rc_reg - 1'b1;
                end
            end
            MODE_BACK:
            begin
                if (lc_reg != '0)
                begin
                    lc_next = lc_reg - 1'b1;
                end
            end
            MODE_INSERT:
            begin
                if (total >= CAP_T)
                begin
                    rsp_next.overflow = 1'b1;
                end
                else
                begin
                    l_we    = 1'b1;
                    l_wdata = cmd_reg.char_in;
                    lc_next = lc_reg + 1'b1;
                end
            end
            MODE_READ:
            begin
                if (pos_ex < lc_ext)
                begin
                    rsp_next.char_out   = l_rdata;
                    rsp_next.char_valid = 1'b1;
                end
                else if (pos_ex < tot_ext)
                begin
                    rsp_next.char_out   = r_rdata;
                    rsp_next.char_valid = 1'b1;
                end
            end
            default:
            begin
                lc_next = lc_reg;
            end
        endcase
        // Stores are written only in the execute phase
        if (state_reg != S_EXEC)
        begin
            l_we = 1'b0;
            r_we = 1'b0;
        end
        rsp_next.cursor      = OUT_CNT_W'(lc_next);
        rsp_next.text_length = OUT_CNT_W'({1'b0, lc_next} + {1'b0, rc_next});
    end

    // Command capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
    end

    // FSM, counts and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lc_reg        <= '0;
            rc_reg        <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (rsp_valid_reg && !rsp_stall)
                    begin
                        rsp_valid_reg <= 1'b0;
                    end
                    if (accept)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    lc_reg        <= lc_next;
                    rc_reg        <= rc_next;
                    rsp_reg       <= rsp_next;
                    rsp_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Left stack: text order, top next to the cursor
    gble_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_left_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    // Right stack: reverse order, top next to the cursor
    gble_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_right_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    // The two stacks never hold more than the capacity together
    a_cap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total <= CAP_T)
        else $error("stack counts exceed capacity");

    // No new command while the previous one is writing back
    a_exec_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> cmd_stall)
        else $error("command accepted during execute phase");

    // A response appears only out of the execute phase
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("response raised outside execute phase");

    // Overflow is flagged only with a full buffer
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(rsp_valid_reg) && rsp_reg.overflow) |-> (total == CAP_T))
        else $error("overflow flagged with room left");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for gap_buffer_line_editor: random edits, cursor walks and reads,
// scored against a behavioral gap-buffer model kept inside this file.
// Depends on gble_pkg and the gap_buffer_line_editor RTL.
`timescale 1ns / 1ps

module tb;
    import gble_pkg::*;

    localparam int CAP          = 1024;
    localparam int STUCK_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 12;

    // Modes with no defined action
    localparam logic [MODE_W-1:0] MODE_SPARE5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    gble_cmd_t  cmd = '0;
    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    gble_rsp_t  rsp;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;

    gap_buffer_line_editor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

    always #5 clk = ~clk;

    // Edit model: two stacks meeting at the cursor
    logic [CHAR_W-1:0] left_text  [CAP];
    logic [CHAR_W-1:0] right_text [CAP];
    int left_len  = 0;
    int right_len = 0;

    gble_cmd_t pending_cmds [$];
    gble_rsp_t expected_rsp [$];

    // Shadow counts used only to steer stimulus generation
    int gen_cursor = 0;
    int gen_total  = 0;

    int errors       = 0;
    int cmds_taken   = 0;
    int rsps_checked = 0;
    int read_hits    = 0;
    int drop_count   = 0;
    int peak_length  = 0;
    int gap_cnt      = 0;
    int stall_cnt    = 0;
    int stuck_cycles = 0;
    bit send_steady  = 1'b0;
    bit recv_steady  = 1'b0;

    function automatic gble_rsp_t apply_edit(gble_cmd_t c);
        gble_rsp_t r;
        int held;
        int pos;
        r    = '0;
        held = left_len + right_len;
        pos  = int'(c.position);
        case (c.mode)
            MODE_LEFT:
                if (left_len > 0 && right_len < CAP) begin
                    left_len--;
                    right_text[right_len] = left_text[left_len];
                    right_len++;
                end
            MODE_RIGHT:
                if (right_len > 0 && left_len < CAP) begin
                    right_len--;
                    left_text[left_len] = right_text[right_len];
                    left_len++;
                end
            MODE_BACK:
                if (left_len > 0)
                    left_len--;
            MODE_INSERT:
                if (held >= CAP) begin
                    r.overflow = 1'b1;
                end else begin
                    left_text[left_len] = c.char_in;
                    left_len++;
                end
            MODE_READ:
                if (pos < left_len) begin
                    r.char_out   = left_text[pos];
                    r.char_valid = 1'b1;
                end else if (pos < held) begin
                    // right stack is stored reversed, top next to the cursor
                    r.char_out   = right_text[right_len - 1 - (pos - left_len)];
                    r.char_valid = 1'b1;
                end
            default: ;
        endcase
        r.cursor      = OUT_CNT_W'(left_len);
        r.text_length = OUT_CNT_W'(left_len + right_len);
        return r;
    endfunction

    // Mostly short idles, a few long ones, with occasional stretches of none
    function automatic int pick_idle(inout bit steady);
        int r;
        if ($urandom_range(0, 99) < 3)
            steady = !steady;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 80)
            return 1;
        if (r < 95)
            return $urandom_range(2, 5);
        return $urandom_range(10, 30);
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t rsp #%0d: %s", $time, rsps_checked, msg);
        errors++;
    endtask

    task automatic queue_cmd(logic [MODE_W-1:0] m, logic [CHAR_W-1:0] ch,
                             logic [POS_W-1:0] pos);
        gble_cmd_t c;
        c.mode     = m;
        c.char_in  = ch;
        c.position = pos;
        pending_cmds.push_back(c);
        case (m)
            MODE_LEFT:   if (gen_cursor > 0) gen_cursor--;
            MODE_RIGHT:  if (gen_cursor < gen_total) gen_cursor++;
            MODE_BACK:
                if (gen_cursor > 0)
                begin
                    gen_cursor--;
                    gen_total--;
                end
            MODE_INSERT:
                if (gen_total < CAP)
                begin
                    gen_cursor++;
                    gen_total++;
                end
            default: ;
        endcase
    endtask

    // One random command; weights in percent, remainder goes to spare modes
    task automatic queue_random(int w_ins, int w_left, int w_right, int w_back, int w_read);
        int r;
        logic [POS_W-1:0] pos;
        logic [CHAR_W-1:0] ch;
        r  = $urandom_range(0, 99);
        ch = CHAR_W'($urandom_range(0, 255));
        if (gen_total > 0 && $urandom_range(0, 3) != 0)
            pos = POS_W'($urandom_range(0, gen_total - 1));
        else
            pos = POS_W'($urandom_range(0, CAP - 1));
        if (r < w_ins)
            queue_cmd(MODE_INSERT, ch, pos);
        else if (r < w_ins + w_left)
            queue_cmd(MODE_LEFT, ch, pos);
        else if (r < w_ins + w_left + w_right)
            queue_cmd(MODE_RIGHT, ch, pos);
        else if (r < w_ins + w_left + w_right + w_back)
            queue_cmd(MODE_BACK, ch, pos);
        else if (r < w_ins + w_left + w_right + w_back + w_read)
            queue_cmd(MODE_READ, ch, pos);
        else
            queue_cmd(MODE_W'($urandom_range(MODE_SPARE5, MODE_SPARE7)), ch, pos);
    endtask

    // Walk the cursor several places in one direction
    task automatic queue_walk();
        int n;
        logic [MODE_W-1:0] dir;
        n   = $urandom_range(5, 40);
        dir = $urandom_range(0, 1) ? MODE_LEFT : MODE_RIGHT;
        repeat (n)
            queue_cmd(dir, CHAR_W'($urandom_range(0, 255)),
                      POS_W'($urandom_range(0, CAP - 1)));
    endtask

    // Command driver: predicts each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            gap_cnt   <= 0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                expected_rsp.push_back(apply_edit(cmd));
                cmds_taken++;
            end
            if (!cmd_valid || !cmd_stall)
            begin
                if (gap_cnt > 0)
                begin
                    cmd_valid <= 1'b0;
                    gap_cnt   <= gap_cnt - 1;
                end
                else if (pending_cmds.size() != 0)
                begin
                    cmd       <= pending_cmds.pop_front();
                    cmd_valid <= 1'b1;
                    gap_cnt   <= pick_idle(send_steady);
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        gble_rsp_t want;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_cnt <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    report_mismatch("response with no command outstanding");
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.char_out !== want.char_out)
                        report_mismatch($sformatf("char_out got %0d want %0d",
                                                  rsp.char_out, want.char_out));
                    if (rsp.char_valid !== want.char_valid)
                        report_mismatch($sformatf("char_valid got %0d want %0d",
                                                  rsp.char_valid, want.char_valid));
                    if (rsp.cursor !== want.cursor)
                        report_mismatch($sformatf("cursor got %0d want %0d",
                                                  rsp.cursor, want.cursor));
                    if (rsp.text_length !== want.text_length)
                        report_mismatch($sformatf("text_length got %0d want %0d",
                                                  rsp.text_length, want.text_length));
                    if (rsp.overflow !== want.overflow)
                        report_mismatch($sformatf("overflow got %0d want %0d",
                                                  rsp.overflow, want.overflow));
                    if (want.char_valid)
                        read_hits++;
                    if (want.overflow)
                        drop_count++;
                    if (int'(want.text_length) > peak_length)
                        peak_length = want.text_length;
                end
                rsps_checked++;
            end
            if (stall_cnt > 0)
            begin
                rsp_stall <= 1'b1;
                stall_cnt <= stall_cnt - 1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                stall_cnt <= pick_idle(recv_steady);
            end
        end
    end

    // Watchdog: no transaction on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles == STUCK_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", STUCK_LIMIT);
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // Stimulus and end of test
    initial
    begin
        // Edges on an empty buffer, reads of nothing, a spare mode
        queue_cmd(MODE_LEFT,   8'h00, 10'd0);
        queue_cmd(MODE_RIGHT,  8'hFF, 10'd1023);
        queue_cmd(MODE_BACK,   8'h00, 10'd0);
        queue_cmd(MODE_READ,   8'h00, 10'd0);
        queue_cmd(MODE_SPARE5, 8'hFF, 10'd1023);
        // Byte extremes, reads in text, past the end and at the top position
        queue_cmd(MODE_INSERT, 8'h00, 10'd0);
        queue_cmd(MODE_INSERT, 8'hFF, 10'd0);
        queue_cmd(MODE_INSERT, 8'h5A, 10'd0);
        queue_cmd(MODE_READ,   8'h00, 10'd0);
        queue_cmd(MODE_READ,   8'h00, 10'd3);
        queue_cmd(MODE_READ,   8'h00, 10'd1023);
        // Cursor to the start, then edges with text right of the cursor
        queue_cmd(MODE_LEFT,   8'h00, 10'd0);
        queue_cmd(MODE_LEFT,   8'h00, 10'd0);
        queue_cmd(MODE_LEFT,   8'h00, 10'd0);
        queue_cmd(MODE_LEFT,   8'h00, 10'd0);
        queue_cmd(MODE_BACK,   8'h00, 10'd0);
        queue_cmd(MODE_READ,   8'h00, 10'd0);
        queue_cmd(MODE_READ,   8'h00, 10'd2);
        // Insert at the front, delete in the middle, cursor to the end edge
        queue_cmd(MODE_INSERT, 8'hA5, 10'd0);
        queue_cmd(MODE_RIGHT,  8'h00, 10'd0);
        queue_cmd(MODE_READ,   8'h00, 10'd1);
        queue_cmd(MODE_BACK,   8'h00, 10'd0);
        queue_cmd(MODE_RIGHT,  8'h00, 10'd0);
        queue_cmd(MODE_RIGHT,  8'h00, 10'd0);
        queue_cmd(MODE_RIGHT,  8'h00, 10'd0);
        queue_cmd(MODE_SPARE6, 8'h00, 10'd0);
        queue_cmd(MODE_SPARE7, 8'hFF, 10'd1023);

        // Grow the text to capacity, mostly inserts with a little cursor traffic
        while (gen_total < CAP)
            queue_random(97, 1, 1, 0, 1);
        // Full buffer: dropped inserts, reads across the whole text
        repeat (20)
            queue_random(40, 10, 10, 0, 38);
        // Shrink and shuffle
        repeat (40)
        begin
            if ($urandom_range(0, 19) == 0)
                queue_walk();
            else
                queue_random(15, 15, 15, 35, 15);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || cmd_valid)
            @(posedge clk);
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d commands taken, %0d responses checked, peak length %0d",
                 cmds_taken, rsps_checked, peak_length);
        $display("%0d reads inside the text, %0d inserts dropped on a full buffer",
                 read_hits, drop_count);
        if (errors == 0 && expected_rsp.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
